// ----- hdl/rba_pkg.sv -----
// ----------------------------------------------------------------------------
// rba_pkg
// Shared widths, register indexes and pipeline tag type for the round brush
// alpha unit.
// ----------------------------------------------------------------------------
package rba_pkg;

  // field widths
  localparam int COORD_W     = 12;
  localparam int Q4_W        = 16;
  localparam int RAMP_W      = 24;
  localparam int COV_W       = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // squared distance and square root sizing
  localparam int SQ_W      = 2 * Q4_W;          // one squared offset
  localparam int SUM_W     = SQ_W + 1;          // dx^2 + dy^2
  localparam int RAD_W     = 42;                // (sum << 8), padded to even
  localparam int SQ_STEPS  = RAD_W / 2;         // one root bit per step
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 1;

  // ramp and smoothstep sizing
  localparam int PROD_W    = ROOT_W + RAMP_W;   // diff * ramp_inverse
  localparam int HALF_RW   = RAMP_W / 2;
  localparam int PART_W    = ROOT_W + HALF_RW;
  localparam int T_W       = 16;
  localparam int U_W       = T_W + 1;
  localparam int W_W       = T_W + 2;

  localparam logic [COV_W-1:0] COV_FULL = '1;
  localparam logic [COV_W-1:0] COV_NONE = '0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_OUTER_RADIUS = 3'd2,
    REG_INNER_RADIUS = 3'd3,
    REG_RAMP_INVERSE = 3'd4
  } rba_reg_t;

  // per-pixel class that rides along the pipeline
  typedef struct packed {
    logic zero;   // outside image or beyond outer radius
    logic full;   // inside inner radius or hard edge
  } rba_tag_t;

endpackage

// ----- hdl/rba_sqrt.sv -----
// ----------------------------------------------------------------------------
// rba_sqrt
// Pipelined integer square root, one root bit resolved per register stage,
// with a class tag carried alongside.
// ----------------------------------------------------------------------------
module rba_sqrt (
  input  logic                        clk,
  input  logic [rba_pkg::SQ_STEPS-1:0] ld,
  input  logic [rba_pkg::RAD_W-1:0]   rad_in,
  input  rba_pkg::rba_tag_t           tag_in,
  output logic [rba_pkg::ROOT_W-1:0]  root_out,
  output rba_pkg::rba_tag_t           tag_out
);
  import rba_pkg::*;

  logic [REM_W-1:0]  rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0] root_r [SQ_STEPS];
  logic [RAD_W-1:0]  rad_r  [SQ_STEPS];
  rba_tag_t          tag_r  [SQ_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      rba_tag_t          tag_prev;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic              take;

      // previous stage, or the pipe input for the first step
      if (k == 0) begin : g_first
        assign rem_prev  = '0;
        assign root_prev = '0;
        assign rad_prev  = rad_in;
        assign tag_prev  = tag_in;
      end else begin : g_next
        assign rem_prev  = rem_r[k-1];
        assign root_prev = root_r[k-1];
        assign rad_prev  = rad_r[k-1];
        assign tag_prev  = tag_r[k-1];
      end

      // bring down two radicand bits, try root*4+1
      assign rem_sh = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (ld[k]) begin
          rem_r[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
          root_r[k] <= {root_prev[ROOT_W-2:0], take};
          rad_r[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
          tag_r[k]  <= tag_prev;
        end
      end
    end
  endgenerate

  assign root_out = root_r[SQ_STEPS-1];
  assign tag_out  = tag_r[SQ_STEPS-1];

endmodule

// ----- hdl/round_brush_alpha_unit.sv -----
// ----------------------------------------------------------------------------
// round_brush_alpha_unit
// Brush coverage per pixel: distance from the brush center, radius tests,
// square root and smoothstep falloff, fully pipelined.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-----------------------------------
//   in_     | in  | tvalid / tready   | tdata: pixel_col[11:0], pixel_row[23:12]
//   out_    | out | tvalid / tready   | tdata: coverage[15:0]
//   cfg_    | in  | we (no wait)      | index, wdata: register value
//
// One pixel is accepted per clock while in_tready is high; each result passes
// through 29 register stages: the offset, square and distance stages, the
// 21-step square root, and the ramp and smoothstep multiply stages. Every
// stage has its own valid bit and loads when it is empty or the stage after
// it moves, so bubbles close up while the output stalls. Reset clears the
// valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module round_brush_alpha_unit #(
  parameter int IMAGE_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rba_pkg::IN_TDATA_W-1:0]  in_tdata,   // pixel_col, pixel_row
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rba_pkg::OUT_TDATA_W-1:0] out_tdata,  // coverage
  input  logic                            cfg_we,
  input  logic [rba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rba_pkg::*;

  localparam int SQ0   = 3;              // first square root stage
  localparam int ST_D  = SQ0 + SQ_STEPS; // ramp offset
  localparam int ST_P1 = ST_D + 1;       // partial products
  localparam int ST_P2 = ST_D + 2;       // ramp sum
  localparam int ST_C1 = ST_D + 3;       // u*u and u+3t
  localparam int ST_C2 = ST_D + 4;       // final product, output register
  localparam int NSTG  = ST_C2 + 1;

  // configuration registers
  logic [Q4_W-1:0]   center_x_r, center_y_r, outer_r, inner_r;
  logic [RAMP_W-1:0] ramp_r;
  logic [SQ_W-1:0]   outer_sq_r, inner_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      outer_r    <= '0;
      inner_r    <= '0;
      ramp_r     <= '0;
    end else if (cfg_we) begin
      case (rba_reg_t'(cfg_index))
        REG_CENTER_X:     center_x_r <= cfg_wdata[Q4_W-1:0];
        REG_CENTER_Y:     center_y_r <= cfg_wdata[Q4_W-1:0];
        REG_OUTER_RADIUS: outer_r    <= cfg_wdata[Q4_W-1:0];
        REG_INNER_RADIUS: inner_r    <= cfg_wdata[Q4_W-1:0];
        REG_RAMP_INVERSE: ramp_r     <= cfg_wdata[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // radius squares are registered from the radius registers, following them in the next cycle
  always_ff @(posedge clk) begin
    outer_sq_r <= outer_r * outer_r;
    inner_sq_r <= inner_r * inner_r;
  end

  // stage valid bits and per-stage load enables
  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NSTG-1];

  // stage A: center offsets and image bounds
  logic [COORD_W-1:0] col, row;
  logic [Q4_W-1:0]    px, py;
  logic [Q4_W-1:0]    dx_r, dy_r;
  logic               oob_a_r;

  assign col = in_tdata[COORD_W-1:0];
  assign row = in_tdata[2*COORD_W-1:COORD_W];
  assign px  = {col, 4'h8};
  assign py  = {row, 4'h8};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r    <= (px >= center_x_r) ? (px - center_x_r) : (center_x_r - px);
      dy_r    <= (py >= center_y_r) ? (py - center_y_r) : (center_y_r - py);
      oob_a_r <= ({1'b0, col} >= (COORD_W+1)'(IMAGE_DIM)) ||
                 ({1'b0, row} >= (COORD_W+1)'(IMAGE_DIM));
    end
  end

  // stage B: squared offsets
  logic [SQ_W-1:0] sqx_r, sqy_r;
  logic            oob_b_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sqx_r   <= dx_r * dx_r;
      sqy_r   <= dy_r * dy_r;
      oob_b_r <= oob_a_r;
    end
  end

  // stage C: squared distance, radius class, root radicand
  logic [SUM_W-1:0] dist_sq;
  logic [RAD_W-1:0] rad_c_r;
  rba_tag_t         tag_c_r;

  assign dist_sq = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rad_c_r      <= {1'b0, dist_sq, 8'h00};
      tag_c_r.zero <= oob_b_r || (dist_sq > {1'b0, outer_sq_r});
      tag_c_r.full <= (dist_sq <= {1'b0, inner_sq_r}) || (ramp_r == '0);
    end
  end

  // square root of the distance in 1/256 pixel units
  logic [ROOT_W-1:0] root;
  rba_tag_t          tag_q;

  rba_sqrt u_sqrt (
    .clk      (clk),
    .ld       (rdy[SQ0 +: SQ_STEPS]),
    .rad_in   (rad_c_r),
    .tag_in   (tag_c_r),
    .root_out (root),
    .tag_out  (tag_q)
  );

  // stage D: distance past the inner radius
  logic [ROOT_W-1:0] diff_r;
  rba_tag_t          tag_d_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_D]) begin
      diff_r  <= root - ROOT_W'({inner_r, 4'h0});
      tag_d_r <= tag_q;
    end
  end

  // stage P1: ramp product split into two halves
  logic [PART_W-1:0] plo_r, phi_r;
  rba_tag_t          tag_p1_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_P1]) begin
      plo_r    <= diff_r * ramp_r[HALF_RW-1:0];
      phi_r    <= diff_r * ramp_r[RAMP_W-1:HALF_RW];
      tag_p1_r <= tag_d_r;
    end
  end

  // stage P2: t in Q.16 and the ramp-ended flag
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    t_r;
  logic              big_p2_r;
  rba_tag_t          tag_p2_r;

  assign prod = {{(PROD_W-PART_W){1'b0}}, plo_r} +
                {phi_r[PART_W-1:0], {HALF_RW{1'b0}}};

  always_ff @(posedge clk) begin
    if (rdy[ST_P2]) begin
      t_r      <= prod[T_W+7:8];
      big_p2_r <= |prod[PROD_W-1:T_W+8];
      tag_p2_r <= tag_p1_r;
    end
  end

  // stage C1: u*u and u + 3t
  logic [U_W-1:0]   u;
  logic [2*U_W-1:0] uu;
  logic [U_W-1:0]   uuh_r;
  logic [W_W-1:0]   w_r;
  logic             big_c1_r;
  rba_tag_t         tag_c1_r;

  assign u  = U_W'(17'h10000) - {1'b0, t_r};
  assign uu = u * u;

  always_ff @(posedge clk) begin
    if (rdy[ST_C1]) begin
      uuh_r    <= uu[U_W+15:16];
      w_r      <= {1'b0, u} + {1'b0, t_r, 1'b0} + {2'b00, t_r};
      big_c1_r <= big_p2_r;
      tag_c1_r <= tag_p2_r;
    end
  end

  // stage C2: final product, saturation and class select
  logic [U_W+W_W-1:0] val;
  logic [U_W+W_W-17:0] cov_wide;
  logic [COV_W-1:0]   cov_nxt, cov_r;

  assign val      = uuh_r * w_r;
  assign cov_wide = val[U_W+W_W-1:16];

  always_comb begin
    if (tag_c1_r.zero) begin
      cov_nxt = COV_NONE;
    end else if (tag_c1_r.full) begin
      cov_nxt = COV_FULL;
    end else if (big_c1_r) begin
      cov_nxt = COV_NONE;
    end else if (|cov_wide[U_W+W_W-17:COV_W]) begin
      cov_nxt = COV_FULL;
    end else begin
      cov_nxt = cov_wide[COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_C2]) begin
      cov_r <= cov_nxt;
    end
  end

  assign out_tdata = cov_r;

endmodule
